FILE: hw/rtl/psinc_pkg.sv
package psinc_pkg;

  localparam int AXES      = 3;
  localparam int AX_IDX_W  = 2;
  localparam int CFG_IDX_W = 2;

  // configuration register map
  localparam logic [CFG_IDX_W-1:0] REG_RES_U = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RES_V = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RES_W = 2'd2;

  // default axis step sizes in machine units
  localparam real STEP_ROT = 0.0018;
  localparam real STEP_LIN = 0.0025;

endpackage

FILE: hw/rtl/position_to_step_increment.sv
// Channel | Direction | Transfer when       | Payload
// in      | input     | in_valid & in_ready | in_pos_u, in_pos_v, in_pos_w
// out     | output    | out_valid & out_ready | out_inc_u/v/w, out_saturated
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// Each item is worked by the single radix-2 divider, which serves the three
// axes in turn, one quotient bit a cycle.
// in_ready is high only while the sequencer is idle.
// Reset is synchronous: last positions and residuals clear, resolutions take defaults.
// A result waiting on out_ready does not block the next input transfer;
// the sequencer only waits before overwriting the output register.
module position_to_step_increment #(
  parameter int POS_WIDTH = 40,
  parameter int FRAC_BITS = 20,
  parameter int INC_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [POS_WIDTH-1:0]          in_pos_u,
  input  logic signed [POS_WIDTH-1:0]          in_pos_v,
  input  logic signed [POS_WIDTH-1:0]          in_pos_w,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [INC_WIDTH-1:0]          out_inc_u,
  output logic signed [INC_WIDTH-1:0]          out_inc_v,
  output logic signed [INC_WIDTH-1:0]          out_inc_w,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [psinc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [FRAC_BITS:0]                   cfg_wdata
);

  localparam int RES_W     = FRAC_BITS + 1;
  localparam int RESID_W   = FRAC_BITS + 4;
  localparam int R_W       = RESID_W + 2;
  localparam int DIST_W    = POS_WIDTH + 1;
  localparam int INC_EXT_W = DIST_W + 1;
  localparam int CMP_W     = (INC_EXT_W > INC_WIDTH) ? INC_EXT_W : INC_WIDTH + 1;

  localparam logic [RES_W-1:0] RES_RST_ROT =
    RES_W'($rtoi(psinc_pkg::STEP_ROT * (2.0 ** FRAC_BITS)));
  localparam logic [RES_W-1:0] RES_RST_LIN =
    RES_W'($rtoi(psinc_pkg::STEP_LIN * (2.0 ** FRAC_BITS)));
  localparam logic signed [CMP_W-1:0] INC_MAX =
    {{(CMP_W-INC_WIDTH+1){1'b0}}, {(INC_WIDTH-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] INC_MIN = ~INC_MAX;
  localparam logic [psinc_pkg::AX_IDX_W-1:0] LAST_AX =
    psinc_pkg::AX_IDX_W'(psinc_pkg::AXES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_DIV,
    S_CARRY,
    S_OUT
  } state_t;

  state_t                              state_r;
  logic [psinc_pkg::AX_IDX_W-1:0]      axis_r;
  logic [RES_W-1:0]                    res_r      [psinc_pkg::AXES];
  logic signed [POS_WIDTH-1:0]         pos_r      [psinc_pkg::AXES];
  logic signed [POS_WIDTH-1:0]         last_r     [psinc_pkg::AXES];
  logic signed [RESID_W-1:0]           resid_r    [psinc_pkg::AXES];
  logic signed [INC_WIDTH-1:0]         lane_r     [psinc_pkg::AXES];
  logic signed [DIST_W-1:0]            dist_r;
  logic                                dist_neg_r;
  logic                                dist_zero_r;
  logic [RES_W-1:0]                    res_eff_r;
  logic signed [INC_EXT_W-1:0]         inc_r;
  logic signed [R_W-1:0]               r_r;
  logic                                sat_acc_r;
  logic                                out_valid_r;
  logic signed [INC_WIDTH-1:0]         out_inc_u_r;
  logic signed [INC_WIDTH-1:0]         out_inc_v_r;
  logic signed [INC_WIDTH-1:0]         out_inc_w_r;
  logic                                out_sat_r;

  logic                                div_start;
  logic [DIST_W-1:0]                   div_num;
  logic                                div_done;
  logic [DIST_W-1:0]                   div_quo;
  logic [RES_W-1:0]                    div_rem;

  logic signed [DIST_W-1:0]            dist_nxt;
  logic [RES_W-1:0]                    res_sel;
  logic signed [INC_EXT_W-1:0]         quo_s;
  logic signed [INC_EXT_W-1:0]         inc_nxt;
  logic signed [R_W-1:0]               rem_s;
  logic signed [R_W-1:0]               r_nxt;
  logic signed [R_W-1:0]               res_s;
  logic signed [R_W-1:0]               r_sum;
  logic signed [R_W-1:0]               r_adj;
  logic signed [INC_EXT_W-1:0]         inc_adj;
  logic signed [CMP_W-1:0]             inc_c;
  logic signed [INC_WIDTH-1:0]         inc_clip;
  logic                                clip;

  always_comb begin
    dist_nxt  = DIST_W'(pos_r[axis_r]) - DIST_W'(last_r[axis_r]);
    res_sel   = res_r[axis_r];
    div_start = (state_r == S_START);
    div_num   = dist_neg_r ? DIST_W'(-dist_r) : DIST_W'(dist_r);

    quo_s   = signed'({1'b0, div_quo});
    inc_nxt = dist_neg_r ? -quo_s : quo_s;
    rem_s   = signed'(R_W'(div_rem));
    r_nxt   = R_W'(resid_r[axis_r]) + (dist_neg_r ? -rem_s : rem_s);

    // carry one step once the residual reaches a full resolution, borrow one once it reaches minus a full resolution
    res_s   = signed'(R_W'(res_eff_r));
    r_sum   = r_r + res_s;
    inc_adj = inc_r;
    r_adj   = r_r;
    if (r_r >= res_s) begin
      inc_adj = inc_r + INC_EXT_W'(1);
      r_adj   = r_r - res_s;
    end else if (r_sum[R_W-1] || (r_sum == R_W'(0))) begin
      inc_adj = inc_r - INC_EXT_W'(1);
      r_adj   = r_sum;
    end

    inc_c = CMP_W'(inc_adj);
    clip  = 1'b0;
    if (inc_c > INC_MAX) begin
      inc_c = INC_MAX;
      clip  = 1'b1;
    end else if (inc_c < INC_MIN) begin
      inc_c = INC_MIN;
      clip  = 1'b1;
    end
    inc_clip = inc_c[INC_WIDTH-1:0];
  end

  psinc_div #(
    .NUM_W (DIST_W),
    .DEN_W (RES_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (res_eff_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
      sat_acc_r   <= 1'b0;
      res_r[psinc_pkg::REG_RES_U] <= RES_RST_ROT;
      res_r[psinc_pkg::REG_RES_V] <= RES_RST_ROT;
      res_r[psinc_pkg::REG_RES_W] <= RES_RST_LIN;
      for (int a = 0; a < psinc_pkg::AXES; a++) begin
        last_r[a]  <= '0;
        resid_r[a] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index < psinc_pkg::CFG_IDX_W'(psinc_pkg::AXES))) begin
        res_r[cfg_index] <= cfg_wdata;
      end
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pos_r[psinc_pkg::REG_RES_U] <= in_pos_u;
            pos_r[psinc_pkg::REG_RES_V] <= in_pos_v;
            pos_r[psinc_pkg::REG_RES_W] <= in_pos_w;
            axis_r    <= '0;
            sat_acc_r <= 1'b0;
            state_r   <= S_LOAD;
          end
        end
        S_LOAD: begin
          dist_r      <= dist_nxt;
          dist_neg_r  <= dist_nxt[DIST_W-1];
          dist_zero_r <= (dist_nxt == DIST_W'(0));
          res_eff_r   <= (res_sel == RES_W'(0)) ? RES_W'(1) : res_sel;
          state_r     <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            inc_r   <= inc_nxt;
            r_r     <= r_nxt;
            state_r <= S_CARRY;
          end
        end
        S_CARRY: begin
          last_r[axis_r] <= pos_r[axis_r];
          if (dist_zero_r) begin
            lane_r[axis_r] <= '0;
          end else begin
            lane_r[axis_r]  <= inc_clip;
            resid_r[axis_r] <= r_adj[RESID_W-1:0];
            sat_acc_r       <= sat_acc_r | clip;
          end
          if (axis_r == LAST_AX) begin
            state_r <= S_OUT;
          end else begin
            axis_r  <= axis_r + psinc_pkg::AX_IDX_W'(1);
            state_r <= S_LOAD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_inc_u_r <= lane_r[psinc_pkg::REG_RES_U];
            out_inc_v_r <= lane_r[psinc_pkg::REG_RES_V];
            out_inc_w_r <= lane_r[psinc_pkg::REG_RES_W];
            out_sat_r   <= sat_acc_r;
            out_valid_r <= 1'b1;
            axis_r      <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_inc_u     = out_inc_u_r;
  assign out_inc_v     = out_inc_v_r;
  assign out_inc_w     = out_inc_w_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_idle_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (axis_r == '0))
    else $error("axis counter not cleared while idle");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOAD))
    else $error("accepted transfer did not start an axis");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ((CMP_W'(out_inc_u) == INC_MAX) || (CMP_W'(out_inc_u) == INC_MIN) ||
       (CMP_W'(out_inc_v) == INC_MAX) || (CMP_W'(out_inc_v) == INC_MIN) ||
       (CMP_W'(out_inc_w) == INC_MAX) || (CMP_W'(out_inc_w) == INC_MIN)))
    else $error("saturated flag without a clipped increment");
`endif

endmodule

FILE: hw/rtl/psinc_div.sv
module psinc_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [NUM_W-1:0] quo_nxt;
  logic [DEN_W-1:0] rem_nxt;

  // one restoring step per cycle, numerator bits leave at the top of quo_r
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    diff    = trial - {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
